FILE: hw/rtl/wmqd_pkg.sv
// types and fixed widths shared by the queue delay estimator files
`default_nettype none

package wmqd_pkg;

    localparam int ARR_W    = 48;
    localparam int SVC_W    = 20;
    localparam int SVC_SQ_W = 2 * SVC_W;
    localparam int WIN_W    = 32;
    localparam int DELAY_W  = 32;

    // window length after reset, in picoseconds
    localparam logic [WIN_W-1:0] WINDOW_RESET = 32'd1000000;

    // utilization cap of 0.99 in integer form: 100 * (w - s) against w
    localparam int PCT_SCALE = 100;

    typedef struct packed {
        logic [ARR_W-1:0] arrival_time;
        logic [SVC_W-1:0] svc_time;
    } wmqd_in_t;

    typedef struct packed {
        logic [DELAY_W-1:0] queue_delay;
        logic               overflow;
    } wmqd_out_t;

endpackage

`default_nettype wire

FILE: hw/rtl/windowed_mg1_queue_delay.sv
// windowed m/g/1 queue delay estimator over a fifo of recent requests
// each evicted entry takes a wait, check and subtract pass; with fewer than two entries left
//   or a zero window the divisions are skipped and the delay is zero
// throughput: one item at a time, the next accepted from the cycle after its result loads; the
//   shared bit-serial divider runs twice per item, or not at all below two entries or at zero window
// reset: synchronous active-low aresetn empties the fifo, clears the sums, window 1000000 ps
`default_nettype none

module windowed_mg1_queue_delay
    import wmqd_pkg::*;
#(
    parameter int WINDOW_DEPTH = 64
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // window register
    input  wire logic             cfg_we,
    input  wire logic [WIN_W-1:0] cfg_wdata,
    // request items
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire wmqd_in_t         s_data,
    // delay items
    output logic                  m_valid,
    input  wire logic             m_ready,
    output wmqd_out_t             m_data
);

    // widths that follow from the fifo depth
    localparam int AW        = $clog2(WINDOW_DEPTH);
    localparam int CW        = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W     = SVC_W + CW;
    localparam int SQ_W      = SVC_SQ_W + CW;
    localparam int NUM_W     = SQ_W + 7;
    localparam int DEN_W     = WIN_W + 8;
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);
    localparam int CMP_W     = (SUM_W > WIN_W) ? SUM_W : WIN_W;
    localparam int PROD_W    = SQ_W + CW;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EV_WAIT,
        ST_EV_CHK,
        ST_EV_SUB,
        ST_DIV1,
        ST_MUL1,
        ST_MUL2,
        ST_DIV2,
        ST_FIN,
        ST_WR,
        ST_OUT
    } state_t;

    state_t              state_reg;
    logic [WIN_W-1:0]    window_reg;
    logic [AW-1:0]       head_reg;
    logic [CW-1:0]       count_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SQ_W-1:0]     sq_sum_reg;
    wmqd_in_t            item_reg;
    logic                ovf_reg;
    logic [DELAY_W-1:0]  delay_reg;
    logic                m_valid_reg;
    wmqd_out_t           m_data_reg;

    // shared restoring divider: dvd_reg shifts out the dividend and collects the quotient
    logic [NUM_W-1:0]     dvd_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     dvs_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic [SQ_W-1:0]      prod_reg;
    logic [DEN_W-1:0]     den_reg;

    // entry memory, read port always on the head entry
    wmqd_in_t             mem [WINDOW_DEPTH];
    wmqd_in_t             rd_data_reg;
    logic [SVC_SQ_W-1:0]  head_sq_reg;
    logic [SVC_SQ_W-1:0]  in_sq_reg;

    logic                 mem_we;
    logic [AW-1:0]        slot;
    logic [AW:0]          slot_sum;

    logic [DEN_W:0]       rem_sh;
    logic [DEN_W:0]       rem_diff;
    logic                 q_bit;
    logic [DEN_W-1:0]     rem_next;
    logic [NUM_W-1:0]     dvd_next;

    logic [ARR_W:0]       head_limit;
    logic                 head_stale;
    logic [AW-1:0]        head_inc;

    logic [CMP_W-1:0]     s_ext;
    logic [CMP_W-1:0]     w_ext;
    logic [WIN_W-1:0]     slack;
    logic [DEN_W-1:0]     slack_pct;
    logic [DEN_W-1:0]     den_half;
    logic [PROD_W-1:0]    prod_full;
    logic [NUM_W-1:0]     num_calc;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // one restoring step per cycle
    always_comb begin
        rem_sh   = {rem_reg, dvd_reg[NUM_W-1]};
        rem_diff = rem_sh - {1'b0, dvs_reg};
        q_bit    = (rem_sh >= {1'b0, dvs_reg});
        rem_next = q_bit ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        dvd_next = {dvd_reg[NUM_W-2:0], q_bit};
    end

    // head entry falls out of the window when arrival + w < new arrival
    always_comb begin
        head_limit = {1'b0, rd_data_reg.arrival_time} + (ARR_W + 1)'(window_reg);
        head_stale = (count_reg != '0) && (head_limit < {1'b0, item_reg.arrival_time});
        head_inc   = (head_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    end

    // tail slot = (head + count) mod depth
    always_comb begin
        slot_sum = (AW + 1)'(head_reg) + (AW + 1)'(count_reg);
        if (slot_sum >= (AW + 1)'(WINDOW_DEPTH)) begin
            slot = AW'(slot_sum - (AW + 1)'(WINDOW_DEPTH));
        end else begin
            slot = AW'(slot_sum);
        end
    end

    // denominator 2 * max(100 * (w - s), w), or 2 * w once the sum reaches the window
    always_comb begin
        s_ext     = CMP_W'(sum_reg);
        w_ext     = CMP_W'(window_reg);
        slack     = WIN_W'(w_ext - s_ext);
        slack_pct = DEN_W'(slack) * DEN_W'(PCT_SCALE);
        if (s_ext >= w_ext) begin
            den_half = DEN_W'(window_reg);
        end else if (slack_pct < DEN_W'(window_reg)) begin
            den_half = DEN_W'(window_reg);
        end else begin
            den_half = slack_pct;
        end
    end

    // n * floor(q / n), then times 100
    always_comb begin
        prod_full = PROD_W'(count_reg) * PROD_W'(dvd_reg[SQ_W-1:0]);
        num_calc  = NUM_W'(prod_reg) * NUM_W'(PCT_SCALE);
    end

    assign mem_we = (state_reg == ST_WR);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[slot] <= item_reg;
        end
        rd_data_reg <= mem[head_reg];
    end

    // squares of the head entry and of the new item for the second-moment sum
    always_ff @(posedge aclk) begin
        head_sq_reg <= SVC_SQ_W'(rd_data_reg.svc_time) * SVC_SQ_W'(rd_data_reg.svc_time);
        in_sq_reg   <= SVC_SQ_W'(item_reg.svc_time) * SVC_SQ_W'(item_reg.svc_time);
    end

    // sequencer: evict, divide, multiply, divide, clamp, store, emit; no divides below two entries or at zero window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            window_reg  <= WINDOW_RESET;
            head_reg    <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            sq_sum_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                window_reg <= cfg_wdata;
            end
            // the output state reloads the register itself
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        item_reg  <= s_data;
                        ovf_reg   <= 1'b0;
                        state_reg <= ST_EV_WAIT;
                    end
                end

                // head read in flight
                ST_EV_WAIT: begin
                    state_reg <= ST_EV_CHK;
                end

                ST_EV_CHK: begin
                    if (head_stale) begin
                        state_reg <= ST_EV_SUB;
                    end else if (count_reg > CW'(1) && window_reg != '0) begin
                        dvd_reg     <= NUM_W'(sq_sum_reg);
                        rem_reg     <= '0;
                        dvs_reg     <= DEN_W'(count_reg);
                        div_cnt_reg <= DIV_CNT_W'(NUM_W);
                        state_reg   <= ST_DIV1;
                    end else begin
                        // fewer than two entries or empty window: delay is zero
                        dvd_reg   <= '0;
                        state_reg <= ST_FIN;
                    end
                end

                ST_EV_SUB: begin
                    sum_reg    <= sum_reg - SUM_W'(rd_data_reg.svc_time);
                    sq_sum_reg <= sq_sum_reg - SQ_W'(head_sq_reg);
                    head_reg   <= head_inc;
                    count_reg  <= count_reg - 1'b1;
                    state_reg  <= ST_EV_WAIT;
                end

                ST_DIV1: begin
                    dvd_reg     <= dvd_next;
                    rem_reg     <= rem_next;
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                    if (div_cnt_reg == DIV_CNT_W'(1)) begin
                        state_reg <= ST_MUL1;
                    end
                end

                ST_MUL1: begin
                    prod_reg  <= SQ_W'(prod_full);
                    den_reg   <= {den_half[DEN_W-2:0], 1'b0};
                    state_reg <= ST_MUL2;
                end

                ST_MUL2: begin
                    dvd_reg     <= num_calc;
                    rem_reg     <= '0;
                    dvs_reg     <= den_reg;
                    div_cnt_reg <= DIV_CNT_W'(NUM_W);
                    state_reg   <= ST_DIV2;
                end

                ST_DIV2: begin
                    dvd_reg     <= dvd_next;
                    rem_reg     <= rem_next;
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                    if (div_cnt_reg == DIV_CNT_W'(1)) begin
                        state_reg <= ST_FIN;
                    end
                end

                // clamp to the window, then drop the oldest entry if the fifo is full
                ST_FIN: begin
                    if (dvd_reg > NUM_W'(window_reg)) begin
                        delay_reg <= window_reg;
                    end else begin
                        delay_reg <= DELAY_W'(dvd_reg);
                    end
                    if (count_reg == CW'(WINDOW_DEPTH)) begin
                        sum_reg    <= sum_reg - SUM_W'(rd_data_reg.svc_time);
                        sq_sum_reg <= sq_sum_reg - SQ_W'(head_sq_reg);
                        head_reg   <= head_inc;
                        count_reg  <= count_reg - 1'b1;
                        ovf_reg    <= 1'b1;
                    end
                    state_reg <= ST_WR;
                end

                // append the item at the tail
                ST_WR: begin
                    count_reg  <= count_reg + 1'b1;
                    sum_reg    <= sum_reg + SUM_W'(item_reg.svc_time);
                    sq_sum_reg <= sq_sum_reg + SQ_W'(in_sq_reg);
                    state_reg  <= ST_OUT;
                end

                // wait for the output register to free up
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg           <= 1'b1;
                        m_data_reg.queue_delay <= delay_reg;
                        m_data_reg.overflow    <= ovf_reg;
                        state_reg             <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/wmqd_checker.sv
// port-level checks for the queue delay estimator and their bind
`default_nettype none

module wmqd_checker
    import wmqd_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             cfg_we,
    input wire logic [WIN_W-1:0] cfg_wdata,
    input wire logic             s_valid,
    input wire logic             s_ready,
    input wire wmqd_in_t         s_data,
    input wire logic             m_valid,
    input wire logic             m_ready,
    input wire wmqd_out_t        m_data
);

    // reset empties the output register
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // one item at a time: accepting an item closes the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input still open after accepting an item");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

    // a new result only follows a freed input side, never while the input is open and idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_ready && !s_valid && !(m_valid && !m_ready)) |=> !(m_valid && !$past(m_valid)))
        else $error("result appeared with no item in work");

endmodule

bind windowed_mg1_queue_delay wmqd_checker u_wmqd_checker (.*);

`default_nettype wire
